// ===== sv/bdpt_pkg.sv =====
// bdpt_pkg: shared types, codes and constants of the button debounce / power timer core
// no dependencies; imported by every module of the block
`default_nettype none

package bdpt_pkg;

  localparam int unsigned NUM_BUTTONS = 8;

  // message codes as reported on the result channel
  typedef enum logic [2:0] {
    MSG_NONE     = 3'd0,
    MSG_PUSHING  = 3'd1,
    MSG_PRESSED  = 3'd2,
    MSG_PUSHED   = 3'd3,
    MSG_RELEASED = 3'd4
  } msg_t;

  // operation codes of an input word
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_RESTAMP = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE_TICKS       = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS_TICKS     = 3'd1;
  localparam logic [2:0] REG_BACKLIGHT_TIMEOUT_MS = 3'd2;
  localparam logic [2:0] REG_POWEROFF_TIMEOUT_MS  = 3'd3;
  localparam logic [2:0] REG_HOLD_POWEROFF_TICKS  = 3'd4;
  localparam logic [2:0] REG_POWER_BUTTON_INDEX   = 3'd5;

  // configuration reset values
  localparam logic [7:0]  DEBOUNCE_TICKS_RST       = 8'd5;
  localparam logic [15:0] LONG_PRESS_TICKS_RST     = 16'd500;
  localparam logic [31:0] BACKLIGHT_TIMEOUT_MS_RST = 32'd30000;
  localparam logic [31:0] POWEROFF_TIMEOUT_MS_RST  = 32'd300000;
  localparam logic [15:0] HOLD_POWEROFF_TICKS_RST  = 16'd1000;
  localparam logic [2:0]  POWER_BUTTON_INDEX_RST   = 3'd0;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [31:0] backlight_timeout_ms;
    logic [31:0] poweroff_timeout_ms;
    logic [15:0] hold_poweroff_ticks;
    logic [2:0]  power_button_index;
  } cfg_t;

  typedef struct packed {
    logic        tracking;
    logic [2:0]  tracked_index;
    logic [7:0]  stable_count;
    logic        wake_swallow;
    msg_t        message;
    logic [15:0] hold_count;
    logic [31:0] activity_stamp;
    logic        backlight_dark;
    logic        shutdown_latched;
  } state_t;

endpackage

`default_nettype wire

// ===== sv/bdpt_step.sv =====
// bdpt_step: next-state logic for one input word (debounce, press classification, timers)
// depends on bdpt_pkg
`default_nettype none

module bdpt_step (
  input  wire bdpt_pkg::cfg_t   cfg_i,
  input  wire bdpt_pkg::state_t st_i,
  input  wire [1:0]             operation_i,
  input  wire [7:0]             buttons_n_i,
  input  wire                   bus_powered_i,
  input  wire [31:0]            now_ms_i,
  output bdpt_pkg::state_t      st_o
);
  import bdpt_pkg::*;

  state_t      st_n;
  logic        pressed;
  logic        off;
  logic [31:0] elapsed;

  always_comb begin
    st_n    = st_i;
    pressed = 1'b0;
    off     = 1'b0;
    elapsed = '0;
    if (!st_i.shutdown_latched) begin
      unique case (operation_i)
        OP_TICK: begin
          if (!st_i.tracking) begin
            // lowest pressed button wins
            for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
              if (!buttons_n_i[i]) begin
                st_n.tracking      = 1'b1;
                st_n.tracked_index = 3'(i);
              end
            end
          end else begin
            pressed = !buttons_n_i[st_i.tracked_index];
            if (pressed) begin
              if (st_i.stable_count < cfg_i.debounce_ticks) begin
                st_n.stable_count = st_i.stable_count + 8'd1;
              end
            end else if (st_i.stable_count != 8'd0) begin
              st_n.stable_count = st_i.stable_count - 8'd1;
            end

            if (st_n.stable_count == cfg_i.debounce_ticks) begin
              // accepted press; a press on a dark backlight only wakes it
              st_n.wake_swallow   = st_i.wake_swallow | st_i.backlight_dark;
              st_n.backlight_dark = 1'b0;
              st_n.activity_stamp = now_ms_i;
              if (!st_n.wake_swallow) begin
                if (st_i.hold_count != HOLD_MAX) begin
                  st_n.hold_count = st_i.hold_count + 16'd1;
                end
                st_n.message = (st_n.hold_count > cfg_i.long_press_ticks) ?
                               MSG_PRESSED : MSG_PUSHING;
              end
            end else if (st_n.stable_count == 8'd0) begin
              // released
              st_n.wake_swallow = 1'b0;
              if (st_i.hold_count >= cfg_i.long_press_ticks) begin
                st_n.message = MSG_RELEASED;
              end else if (st_i.hold_count != 16'd0) begin
                st_n.message = MSG_PUSHED;
              end else begin
                st_n.message       = MSG_NONE;
                st_n.tracking      = 1'b0;
                st_n.tracked_index = 3'd0;
                st_n.hold_count    = 16'd0;
              end
            end
          end

          if (st_n.message == MSG_NONE) begin
            if (bus_powered_i) begin
              elapsed = now_ms_i - st_n.activity_stamp;
              if (elapsed >= cfg_i.poweroff_timeout_ms) begin
                off = 1'b1;
              end else if (elapsed >= cfg_i.backlight_timeout_ms) begin
                st_n.backlight_dark = 1'b1;
              end
            end else begin
              st_n.activity_stamp = now_ms_i;
            end
          end

          // long hold of the power button
          if (bus_powered_i && st_n.message == MSG_PRESSED && st_n.tracking &&
              st_n.tracked_index == cfg_i.power_button_index &&
              st_n.hold_count >= cfg_i.hold_poweroff_ticks) begin
            off = 1'b1;
          end

          if (off) begin
            st_n.shutdown_latched = 1'b1;
          end
        end
        OP_ACK: begin
          st_n.message       = MSG_NONE;
          st_n.tracking      = 1'b0;
          st_n.tracked_index = 3'd0;
          st_n.hold_count    = 16'd0;
        end
        OP_RESTAMP: begin
          st_n.activity_stamp = now_ms_i;
        end
        default: begin
          st_n = st_i;
        end
      endcase
    end
  end

  assign st_o = st_n;

endmodule

`default_nettype wire

// ===== sv/button_debounce_press_power_timer_core.sv =====
// button_debounce_press_power_timer_core: top level of the button / power timer block
// depends on bdpt_pkg and bdpt_step
//
// usage
//   input channel: one word per tick or command (in_operation, in_buttons_n,
//     in_bus_powered, in_now_ms), accepted when in_valid is high and in_stall low
//   result channel: exactly one result word per input word, in order, accepted
//     when out_valid is high and out_stall low
//   config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready are
//     high; cfg_ready is always high; write only while the block is idle
//   latency: the result of a word is in the output register one cycle after it
//     is accepted
//   throughput: one word per cycle; the whole step (debounce count, hold count,
//     one 32-bit elapsed-time subtract and compare) sits between the state
//     registers and the output register
//   stall: while a result waits in the output register and out_stall is high,
//     in_stall is raised; as soon as the result leaves, a new word is taken in
//     the same cycle
//   reset (rst_n low, synchronous): state cleared, registers back to their
//     defaults, output register empty; no clearing pass is needed
`default_nettype none

module button_debounce_press_power_timer_core (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [1:0]   in_operation,
  input  wire [7:0]   in_buttons_n,
  input  wire         in_bus_powered,
  input  wire [31:0]  in_now_ms,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_message,
  output logic [2:0]  out_button_index,
  output logic        out_button_selected,
  output logic [15:0] out_press_ticks,
  output logic        out_backlight_on,
  output logic        out_power_off,
  // configuration channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [2:0]   cfg_index,
  input  wire [31:0]  cfg_data
);
  import bdpt_pkg::*;

  cfg_t   cfg_r;
  state_t st_r;
  state_t st_nxt;
  logic   in_accept;
  logic   out_valid_r;

  // result payload register
  logic [2:0]  message_r;
  logic [2:0]  button_index_r;
  logic        button_selected_r;
  logic [15:0] press_ticks_r;
  logic        backlight_on_r;
  logic        power_off_r;

  // the output register is free when empty or being drained this cycle
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  bdpt_step u_step (
    .cfg_i         (cfg_r),
    .st_i          (st_r),
    .operation_i   (in_operation),
    .buttons_n_i   (in_buttons_n),
    .bus_powered_i (in_bus_powered),
    .now_ms_i      (in_now_ms),
    .st_o          (st_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks       <= DEBOUNCE_TICKS_RST;
      cfg_r.long_press_ticks     <= LONG_PRESS_TICKS_RST;
      cfg_r.backlight_timeout_ms <= BACKLIGHT_TIMEOUT_MS_RST;
      cfg_r.poweroff_timeout_ms  <= POWEROFF_TIMEOUT_MS_RST;
      cfg_r.hold_poweroff_ticks  <= HOLD_POWEROFF_TICKS_RST;
      cfg_r.power_button_index   <= POWER_BUTTON_INDEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS:       cfg_r.debounce_ticks       <= cfg_data[7:0];
        REG_LONG_PRESS_TICKS:     cfg_r.long_press_ticks     <= cfg_data[15:0];
        REG_BACKLIGHT_TIMEOUT_MS: cfg_r.backlight_timeout_ms <= cfg_data;
        REG_POWEROFF_TIMEOUT_MS:  cfg_r.poweroff_timeout_ms  <= cfg_data;
        REG_HOLD_POWEROFF_TICKS:  cfg_r.hold_poweroff_ticks  <= cfg_data[15:0];
        REG_POWER_BUTTON_INDEX:   cfg_r.power_button_index   <= cfg_data[2:0];
        default: begin
          // unmapped index: write ignored
        end
      endcase
    end
  end

  // block state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.tracking         <= 1'b0;
      st_r.tracked_index    <= 3'd0;
      st_r.stable_count     <= 8'd0;
      st_r.wake_swallow     <= 1'b0;
      st_r.message          <= MSG_NONE;
      st_r.hold_count       <= 16'd0;
      st_r.activity_stamp   <= 32'd0;
      st_r.backlight_dark   <= 1'b0;
      st_r.shutdown_latched <= 1'b0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload, loaded from the new state of each accepted word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      message_r         <= st_nxt.message;
      button_index_r    <= st_nxt.tracked_index;
      button_selected_r <= st_nxt.tracking;
      press_ticks_r     <= st_nxt.hold_count;
      backlight_on_r    <= ~st_nxt.backlight_dark;
      power_off_r       <= st_nxt.shutdown_latched;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_message         = message_r;
  assign out_button_index    = button_index_r;
  assign out_button_selected = button_selected_r;
  assign out_press_ticks     = press_ticks_r;
  assign out_backlight_on    = backlight_on_r;
  assign out_power_off       = power_off_r;

endmodule

`default_nettype wire

// ===== sv/bdpt_checker.sv =====
// bdpt_checker: port-level assertions for the button / power timer core, with its bind
// depends on bdpt_pkg and button_debounce_press_power_timer_core
`default_nettype none

module bdpt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [2:0]  out_message,
  input wire [2:0]  out_button_index,
  input wire        out_button_selected,
  input wire        out_power_off
);
  import bdpt_pkg::*;

  // input is only held off by a result that cannot leave
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised without a stalled result");

  // power-off is sticky across successive results
  a_power_off_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_power_off) |=> (!out_valid || out_power_off))
    else $error("power-off dropped after being latched");

  // no tracked button means index zero
  a_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_button_selected) |-> (out_button_index == 3'd0))
    else $error("button index set with no button tracked");

  // any message belongs to a tracked button
  a_msg_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_message != MSG_NONE) |-> out_button_selected)
    else $error("message reported with no button tracked");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_message)))
    else $error("stalled result changed");

endmodule

bind button_debounce_press_power_timer_core bdpt_checker u_bdpt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_message         (out_message),
  .out_button_index    (out_button_index),
  .out_button_selected (out_button_selected),
  .out_power_off       (out_power_off)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for button_debounce_press_power_timer_core
// depends on bdpt_pkg and the core; a scoreboard class predicts one report per word
`timescale 1ns / 100ps

module tb_top;
  import bdpt_pkg::*;

  // operation code the block leaves alone
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // how bus power is chosen for a run of words
  localparam int BUS_OFF    = 0;
  localparam int BUS_MOSTLY = 1;
  localparam int BUS_EITHER = 2;

  // one report word as seen on the result channel
  typedef struct packed {
    msg_t        message;
    logic [2:0]  index;
    logic        selected;
    logic [15:0] ticks;
    logic        light_on;
    logic        power_off;
  } report_t;

  // predicts the report of every accepted word and holds it until the block
  // delivers its own
  class press_report_board;
    cfg_t        regs;
    state_t      st;
    report_t     pending_reports[$];
    int unsigned mismatches;
    int unsigned reports_checked;

    function new();
      regs.debounce_ticks       = DEBOUNCE_TICKS_RST;
      regs.long_press_ticks     = LONG_PRESS_TICKS_RST;
      regs.backlight_timeout_ms = BACKLIGHT_TIMEOUT_MS_RST;
      regs.poweroff_timeout_ms  = POWEROFF_TIMEOUT_MS_RST;
      regs.hold_poweroff_ticks  = HOLD_POWEROFF_TICKS_RST;
      regs.power_button_index   = POWER_BUTTON_INDEX_RST;
      st         = '0;
      st.message = MSG_NONE;
      mismatches      = 0;
      reports_checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_DEBOUNCE_TICKS:       regs.debounce_ticks       = data[7:0];
        REG_LONG_PRESS_TICKS:     regs.long_press_ticks     = data[15:0];
        REG_BACKLIGHT_TIMEOUT_MS: regs.backlight_timeout_ms = data;
        REG_POWEROFF_TIMEOUT_MS:  regs.poweroff_timeout_ms  = data;
        REG_HOLD_POWEROFF_TICKS:  regs.hold_poweroff_ticks  = data[15:0];
        REG_POWER_BUTTON_INDEX:   regs.power_button_index   = data[2:0];
        default: ;
      endcase
    endfunction

    function void drop_press();
      st.message       = MSG_NONE;
      st.tracking      = 1'b0;
      st.tracked_index = 3'd0;
      st.hold_count    = 16'd0;
    endfunction

    function void tick(logic [7:0] pins, logic bus, logic [31:0] now);
      logic        off;
      logic [31:0] elapsed;
      off = 1'b0;
      if (!st.tracking) begin
        // latch the lowest pressed button, no debounce counting this tick
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (!st.tracking && !pins[i]) begin
            st.tracking      = 1'b1;
            st.tracked_index = 3'(i);
          end
        end
      end else begin
        if (!pins[st.tracked_index]) begin
          if (st.stable_count < regs.debounce_ticks)
            st.stable_count = st.stable_count + 8'd1;
        end else if (st.stable_count != 8'd0) begin
          st.stable_count = st.stable_count - 8'd1;
        end
        if (st.stable_count == regs.debounce_ticks) begin
          // a press that only wakes the dark backlight is swallowed
          if (!st.wake_swallow && st.backlight_dark)
            st.wake_swallow = 1'b1;
          st.backlight_dark = 1'b0;
          st.activity_stamp = now;
          if (!st.wake_swallow) begin
            if (st.hold_count != HOLD_MAX)
              st.hold_count = st.hold_count + 16'd1;
            st.message = (st.hold_count > regs.long_press_ticks) ? MSG_PRESSED : MSG_PUSHING;
          end
        end else if (st.stable_count == 8'd0) begin
          st.wake_swallow = 1'b0;
          if (st.hold_count >= regs.long_press_ticks)
            st.message = MSG_RELEASED;
          else if (st.hold_count != 16'd0)
            st.message = MSG_PUSHED;
          else
            drop_press();
        end
      end
      if (st.message == MSG_NONE) begin
        if (bus) begin
          elapsed = now - st.activity_stamp;
          if (elapsed >= regs.poweroff_timeout_ms)
            off = 1'b1;
          else if (elapsed >= regs.backlight_timeout_ms)
            st.backlight_dark = 1'b1;
        end else begin
          st.activity_stamp = now;
        end
      end
      if (bus && st.message == MSG_PRESSED && st.tracking &&
          st.tracked_index == regs.power_button_index &&
          st.hold_count >= regs.hold_poweroff_ticks)
        off = 1'b1;
      if (off)
        st.shutdown_latched = 1'b1;
    endfunction

    function void note_word(logic [1:0] op, logic [7:0] pins, logic bus, logic [31:0] now);
      report_t rep;
      if (!st.shutdown_latched) begin
        case (op)
          OP_TICK:    tick(pins, bus, now);
          OP_ACK:     drop_press();
          OP_RESTAMP: st.activity_stamp = now;
          default: ;
        endcase
      end
      rep.message   = st.message;
      rep.index     = st.tracked_index;
      rep.selected  = st.tracking;
      rep.ticks     = st.hold_count;
      rep.light_on  = !st.backlight_dark;
      rep.power_off = st.shutdown_latched;
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_word(report_t got);
      report_t want;
      reports_checked++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none actual message %0d",
                 $time, got.message);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("message", want.message, got.message);
        compare_field("button_index", want.index, got.index);
        compare_field("button_selected", want.selected, got.selected);
        compare_field("press_ticks", want.ticks, got.ticks);
        compare_field("backlight_on", want.light_on, got.light_on);
        compare_field("power_off", want.power_off, got.power_off);
      end
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_operation = OP_TICK;
  logic [7:0]  in_buttons_n = 8'hFF;
  logic        in_bus_powered = 1'b0;
  logic [31:0] in_now_ms = 32'd0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = REG_DEBOUNCE_TICKS;
  logic [31:0] cfg_data = 32'd0;
  wire         in_stall;
  wire         out_valid;
  wire  [2:0]  out_message;
  wire  [2:0]  out_button_index;
  wire         out_button_selected;
  wire  [15:0] out_press_ticks;
  wire         out_backlight_on;
  wire         out_power_off;
  wire         cfg_ready;

  press_report_board board;
  logic [31:0]       wall_ms = 32'd0;   // free-running millisecond time fed to the block
  logic              calm = 1'b0;       // no random idling on either side while set
  int unsigned       words_sent = 0;
  int unsigned       settings_used = 1; // reset defaults count as the first setting

  always #4 clk = ~clk;

  button_debounce_press_power_timer_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_buttons_n        (in_buttons_n),
    .in_bus_powered      (in_bus_powered),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_message         (out_message),
    .out_button_index    (out_button_index),
    .out_button_selected (out_button_selected),
    .out_press_ticks     (out_press_ticks),
    .out_backlight_on    (out_backlight_on),
    .out_power_off       (out_power_off),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // offer one word; entered and left just after a rising edge. handshakes are
  // sampled on the falling edge, where nothing can still be moving
  task automatic send_word(logic [1:0] op, logic [7:0] pins, logic bus, logic [31:0] now);
    int unsigned gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(0, 99) < 32) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_buttons_n   <= pins;
    in_bus_powered <= bus;
    in_now_ms      <= now;
    do @(negedge clk); while (in_stall);
    // taken at the coming edge
    board.note_word(op, pins, bus, now);
    words_sent++;
    @(posedge clk);
  endtask

  function automatic logic pick_bus(int mode);
    case (mode)
      BUS_OFF:    return 1'b0;
      BUS_MOSTLY: return $urandom_range(0, 9) != 0;
      default:    return $urandom_range(0, 1) == 1;
    endcase
  endfunction

  // a tick up to two milliseconds after the previous one
  task automatic tick_word(logic [7:0] pins, logic bus);
    wall_ms += $urandom_range(0, 2);
    send_word(OP_TICK, pins, bus, wall_ms);
  endtask

  // stop offering and wait until every report has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
  endtask

  // valid is left high so back-to-back writes need no second assignment
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] deb, logic [15:0] lng, logic [31:0] dark_ms,
                                logic [31:0] off_ms, logic [15:0] hold_off, logic [2:0] pwr);
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 32'(deb));
    write_reg(REG_LONG_PRESS_TICKS, 32'(lng));
    write_reg(REG_BACKLIGHT_TIMEOUT_MS, dark_ms);
    write_reg(REG_POWEROFF_TIMEOUT_MS, off_ms);
    write_reg(REG_HOLD_POWEROFF_TICKS, 32'(hold_off));
    write_reg(REG_POWER_BUTTON_INDEX, 32'(pwr));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // contact bounce: now and then the tracked pin shows the wrong level
  function automatic logic [7:0] jitter(logic [7:0] pins, int unsigned btn);
    logic [7:0] p;
    p = pins;
    if ($urandom_range(0, 19) == 0)
      p[btn] = ~p[btn];
    return p;
  endfunction

  // mostly whole press/release episodes with random content, the rest idle
  // stretches, commands and plain noise
  task automatic run_random(int unsigned n, int bus_mode, logic [31:0] jump_max);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned btn;
    int unsigned deb;
    int unsigned reach;
    logic [7:0]  pins;
    stop_at = words_sent + n;
    deb     = board.regs.debounce_ticks;
    reach   = board.regs.long_press_ticks + 4;
    if (reach > 40)
      reach = 40;
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // press: the chosen button is the lowest pressed one, others random
        btn = $urandom_range(0, NUM_BUTTONS - 1);
        pins = 8'($urandom) | ((8'd1 << btn) - 8'd1);
        pins[btn] = 1'b0;
        repeat (1 + deb + deb / 4 + $urandom_range(0, reach)) begin
          if ($urandom_range(0, 99) == 0)
            send_word(OP_ACK, 8'($urandom), pick_bus(bus_mode), wall_ms);
          tick_word(jitter(pins, btn), pick_bus(bus_mode));
        end
        // release, other pins left to chance
        pins = 8'($urandom);
        pins[btn] = 1'b1;
        repeat (deb + deb / 4 + $urandom_range(0, 3))
          tick_word(jitter(pins, btn), pick_bus(bus_mode));
        if ($urandom_range(0, 99) < 80)
          send_word(OP_ACK, 8'($urandom), pick_bus(bus_mode), wall_ms);
      end else if (kind < 80) begin
        // nobody touches anything while time runs on
        repeat ($urandom_range(1, 6)) begin
          wall_ms += $urandom_range(0, jump_max);
          send_word(OP_TICK, 8'hFF, pick_bus(bus_mode), wall_ms);
        end
      end else if (kind < 88) begin
        send_word(OP_RESTAMP, 8'($urandom), pick_bus(bus_mode), wall_ms);
      end else if (kind < 93) begin
        send_word(OP_ACK, 8'($urandom), pick_bus(bus_mode), wall_ms);
      end else if (kind < 96) begin
        send_word(OP_UNUSED, 8'($urandom), pick_bus(bus_mode), $urandom);
      end else begin
        send_word(OP_TICK, 8'($urandom), pick_bus(bus_mode), $urandom);
      end
    end
  endtask

  // result side: random stall, one long hold-off once the block has been
  // running a while, checked on the falling edge like the input side
  initial begin : result_side
    int unsigned hold_left;
    report_t     got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= $urandom_range(0, 99) < 32;
      end
      @(negedge clk);
      if (out_valid && !out_stall) begin
        got.message   = msg_t'(out_message);
        got.index     = out_button_index;
        got.selected  = out_button_selected;
        got.ticks     = out_press_ticks;
        got.light_on  = out_backlight_on;
        got.power_off = out_power_off;
        board.check_word(got);
        // sender keeps offering meanwhile, so the block fills and stalls its input
        if (board.reports_checked == 500)
          hold_left = 300;
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] off_ms;
    logic [15:0] hold_off;
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: unused operation, restamp near the top of the time range,
    // a quiet tick, latch of the highest button across the wrap, acknowledge
    send_word(OP_UNUSED, 8'h00, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_RESTAMP, 8'h00, 1'b1, 32'hFFFF_FFF0);
    send_word(OP_TICK, 8'hFF, 1'b1, 32'hFFFF_FFF5);
    send_word(OP_TICK, 8'h7F, 1'b0, 32'd0);
    send_word(OP_TICK, 8'h00, 1'b0, 32'd1);
    send_word(OP_ACK, 8'hFF, 1'b0, 32'd1);

    // short debounce and thresholds so the directed cases stay brief
    apply_settings(8'd2, 16'd3, 32'd10, 32'hFFFF_FFFF, 16'hFFFF, 3'd7);
    wall_ms = 32'd1000;
    send_word(OP_RESTAMP, 8'hFF, 1'b1, wall_ms);
    // button 0 held past the long threshold, then released: long released
    repeat (7) tick_word(8'hFE, 1'b1);
    repeat (2) tick_word(8'hFF, 1'b1);
    send_word(OP_ACK, 8'h00, 1'b1, wall_ms);
    // idle past the backlight timeout, then a press that only wakes the display
    wall_ms += 20;
    send_word(OP_TICK, 8'hFF, 1'b1, wall_ms);
    repeat (4) tick_word(8'hFB, 1'b1);
    repeat (2) tick_word(8'hFF, 1'b1);

    // debounce and long threshold of one, timeouts out of reach
    apply_settings(8'd1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd0);
    run_random(300, BUS_EITHER, 32'd1000);

    // backlight timeout that the idle stretches reach; no idling at all here,
    // and the long receiver hold-off falls in this phase
    apply_settings(8'd3, 16'd20, 32'd40, 32'hFFFF_FFFF, 16'hFFFF, 3'($urandom));
    calm = 1'b1;
    run_random(300, BUS_MOSTLY, 32'd60);
    settle();
    calm = 1'b0;

    // zero debounce, zero timeouts and zero hold threshold, off bus power
    apply_settings(8'd0, 16'd10, 32'd0, 32'd0, 16'd0, 3'd7);
    run_random(200, BUS_OFF, 32'd100);

    // longest debounce and long threshold, backlight dark whenever idle; one
    // press episode alone runs to several hundred words
    apply_settings(8'd255, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 3'($urandom));
    run_random(100, BUS_EITHER, 32'd5);

    // middling random settings with the millisecond time wrapping
    apply_settings(8'($urandom_range(1, 8)), 16'($urandom_range(1, 40)),
                   $urandom_range(0, 200), 32'hFFFF_FFFF, 16'hFFFF, 3'($urandom));
    wall_ms = 32'hFFFF_FF00;
    run_random(200, BUS_MOSTLY, board.regs.backlight_timeout_ms + 20);

    // last phase ends in power-off, either by holding the power button or by
    // idling past the timeout; words after that only report the frozen state
    if ($urandom_range(0, 1) == 1) begin
      off_ms   = 32'hFFFF_FFFF;
      hold_off = 16'($urandom_range(4, 6));
    end else begin
      off_ms   = 32'd120;
      hold_off = 16'hFFFF;
    end
    apply_settings(8'd2, 16'd3, 32'd30, off_ms, hold_off, 3'($urandom));
    run_random(150, BUS_MOSTLY, 32'd40);

    settle();
    repeat (4) @(posedge clk);
    board.mismatches += board.pending_reports.size();
    $display("%0d words sent under %0d register settings, %0d reports checked",
             words_sent, settings_used, board.reports_checked);
    $display("power-off latched at the end: %0d, mismatches: %0d",
             board.st.shutdown_latched, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
